### rtl/fpm_pkg.sv
// Shared types and constants for the binary32 multiplier pipeline.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package fpm_pkg;
   localparam logic [31:0] QNAN = 32'h7FC0_0000;
   localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

   // Decoded operand pair handed from the unpack stage to the multiply stage.
   typedef struct packed {
      logic        sign;
      logic        special;    // result already fixed (NaN, inf, zero)
      logic [31:0] special_val;
      logic [23:0] sig_a;
      logic [23:0] sig_b;
      logic signed [10:0] exp_sum;  // xa + xb - 127
   } unpacked_type;

   // Product handed from the multiply stage to the round stage.
   typedef struct packed {
      logic        sign;
      logic        special;
      logic [31:0] special_val;
      logic [47:0] prod;
      logic signed [10:0] exp_sum;
   } product_type;

   // Leading-zero count of a 24-bit significand, 24 for all zero.
   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd24;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction
endpackage

### rtl/fpm_unpack.sv
// Stage 1 logic: classifies operands, normalizes subnormal significands.
// Depends on fpm_pkg.
`timescale 1ns / 1ps
module fpm_unpack (
   input  logic [31:0]          op_a,
   input  logic [31:0]          op_b,
   output fpm_pkg::unpacked_type dec
);
   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic        za, zb, na, nb, ia, ib, sign;
   logic [4:0]  la, lb;
   logic signed [10:0] xa, xb;

   always_comb begin
      ea = op_a[30:23];
      eb = op_b[30:23];
      fa = op_a[22:0];
      fb = op_b[22:0];
      sign = op_a[31] ^ op_b[31];
      za = (ea == 8'd0) && (fa == 23'd0);
      zb = (eb == 8'd0) && (fb == 23'd0);
      na = (ea == fpm_pkg::EXP_ALL_ONES) && (fa != 23'd0);
      nb = (eb == fpm_pkg::EXP_ALL_ONES) && (fb != 23'd0);
      ia = (ea == fpm_pkg::EXP_ALL_ONES);
      ib = (eb == fpm_pkg::EXP_ALL_ONES);
      la = fpm_pkg::lzc24({1'b0, fa});
      lb = fpm_pkg::lzc24({1'b0, fb});

      dec.sign = sign;
      dec.special = 1'b1;
      if (na || nb) begin
         dec.special_val = fpm_pkg::QNAN;
      end else if (ia || ib) begin
         dec.special_val = (za || zb) ? fpm_pkg::QNAN : {sign, 31'h7F80_0000};
      end else if (za || zb) begin
         dec.special_val = {sign, 31'd0};
      end else begin
         dec.special = 1'b0;
         dec.special_val = 32'd0;
      end

      if (ea == 8'd0) begin
         dec.sig_a = {1'b0, fa} << la;
         xa = 11'sd1 - signed'({6'd0, la});
      end else begin
         dec.sig_a = {1'b1, fa};
         xa = signed'({3'd0, ea});
      end
      if (eb == 8'd0) begin
         dec.sig_b = {1'b0, fb} << lb;
         xb = 11'sd1 - signed'({6'd0, lb});
      end else begin
         dec.sig_b = {1'b1, fb};
         xb = signed'({3'd0, eb});
      end
      dec.exp_sum = xa + xb - 11'sd127;
   end
endmodule

### rtl/fpm_round.sv
// Stage 3 logic: normalizes the product, denormalizes, rounds to nearest even.
// Depends on fpm_pkg.
`timescale 1ns / 1ps
module fpm_round (
   input  fpm_pkg::product_type prd,
   output logic [31:0]          product
);
   logic [47:0] p;
   logic signed [10:0] e;
   logic [5:0]  shift;
   logic [48:0] wide, keep;
   logic [24:0] q;
   logic        guard, sticky, up;

   always_comb begin
      e = prd.exp_sum;
      if (prd.prod[47]) begin
         p = prd.prod;
         e = prd.exp_sum + 11'sd1;
      end else begin
         p = {prd.prod[46:0], 1'b0};
      end
      // Extra right shift past the normal 24 for tiny results, capped at 25.
      if (e >= 11'sd1) shift = 6'd0;
      else if (e < -11'sd24) shift = 6'd25;
      else shift = 6'(11'sd1 - e);
      // Keep one extra low bit so the guard survives the shift.
      wide = {p, 1'b0} >> shift;
      keep = ({p, 1'b0} & ~(49'h1_FFFF_FFFF_FFFF << shift));
      q = {1'b0, wide[48:25]};
      guard = wide[24];
      sticky = (wide[23:0] != 24'd0) || (keep != 49'd0);
      up = guard && (sticky || q[0]);
      q = q + 25'(up);
      if (prd.special) begin
         product = prd.special_val;
      end else if (e >= 11'sd1) begin
         if (q[24]) begin
            e = e + 11'sd1;
            q = q >> 1;
         end
         if (e >= 11'sd255) product = {prd.sign, 31'h7F80_0000};
         else product = {prd.sign, e[7:0], q[22:0]};
      end else begin
         product = {prd.sign, q[23:0] == 24'h80_0000 ? 31'h0080_0000 : {8'd0, q[22:0]}};
      end
   end
endmodule

### rtl/float32_multiplier_core.sv
// Top level of the IEEE 754 binary32 multiplier: a three-stage pipeline.
// Depends on fpm_pkg, fpm_unpack and fpm_round.
//
//   channel  | direction | tdata bits (lowest first)
//   req      | in        | [31:0] op_a, [63:32] op_b
//   rsp      | out       | [31:0] product
//
// Every request yields one product, carried through s1_ff, s2_ff and s3_ff in turn.
// A new request is taken every cycle; the pipeline moves as a whole and holds
// when its last stage is full and the result is not taken.
// Reset clears the stage valid bits only; the data registers need none.
`timescale 1ns / 1ps
module float32_multiplier_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // op_a [31:0], op_b [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // product [31:0]
);
   fpm_pkg::unpacked_type dec_in, s1_ff;
   fpm_pkg::product_type  s2_ff, s2_in;
   logic [31:0] res_in, s3_ff;
   logic v1_ff, v2_ff, v3_ff, adv;

   // The whole pipe advances unless the output holds an untaken product.
   assign adv = !v3_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata = s3_ff;

   fpm_unpack u_unpack (.op_a(req_tdata[31:0]), .op_b(req_tdata[63:32]), .dec(dec_in));

   // Stage 2 is the 24 by 24 significand multiply.
   always_comb begin
      s2_in.sign = s1_ff.sign;
      s2_in.special = s1_ff.special;
      s2_in.special_val = s1_ff.special_val;
      s2_in.prod = 48'(s1_ff.sig_a) * 48'(s1_ff.sig_b);
      s2_in.exp_sum = s1_ff.exp_sum;
   end

   fpm_round u_round (.prd(s2_ff), .product(res_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= dec_in;
         s2_ff <= s2_in;
         s3_ff <= res_in;
      end
   end
endmodule
